// ===== rtl/mfa_pkg.sv =====
// Shared constants, types and register codes of the multichannel frame averager.
// Depends on nothing; every other file of the block refers to it by scoped names.
package mfa_pkg;

  localparam int NUM_SENSORS       = 6;
  localparam int MAX_FRAME_SAMPLES = 128;

  localparam int UNIT_W     = 2;
  localparam int CHAN_W     = 4;
  localparam int RAW_W      = 12;
  localparam int SENS_NUM_W = 3;
  localparam int AVG_W      = 12;
  localparam int MV_W       = 16;

  localparam int CHMAP_W    = 24;
  localparam int UMAP_W     = 6;
  localparam int FS_W       = 16;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CHMAP_W-1:0] RESET_CHANNEL_MAP = 24'h547630;
  localparam logic [UMAP_W-1:0]  RESET_UNIT_MAP    = 6'd0;
  localparam logic [FS_W-1:0]    RESET_FULL_SCALE  = 16'd2450;

  localparam logic [CHAN_W-1:0] MAX_CHANNEL = 4'd9;
  localparam logic [UNIT_W-1:0] MAX_UNIT    = 2'd1;
  localparam logic [RAW_W-1:0]  MAX_RAW     = {RAW_W{1'b1}};

  // Sensor index, frame counters and sums.
  localparam int IDX_W   = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int COUNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SUM_W   = $clog2(MAX_FRAME_SAMPLES * 4095 + 1);

  // Average times full scale, before the division by the full-scale count.
  localparam int PROD_W     = AVG_W + FS_W;

  // Shared divider: frame sum over frame count.
  localparam int DIV_DW     = SUM_W;
  localparam int DIV_VW     = COUNT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_DW + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_MAP = 2'd0,
    CFG_UNIT_MAP    = 2'd1,
    CFG_FULL_SCALE  = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic [CHAN_W-1:0] channel;
    logic [RAW_W-1:0]  adc_code;
  } sample_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } acc_rd_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_DW-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/mfa_channels.sv =====
// Valid/ready channel interfaces for the sample requests and the result requests.
// Depends on mfa_pkg for the field widths.
interface mfa_in_if;
  logic                          valid;
  logic                          ready;
  logic [mfa_pkg::UNIT_W-1:0]    unit;
  logic [mfa_pkg::CHAN_W-1:0]    channel;
  logic [mfa_pkg::RAW_W-1:0]     adc_code;
  logic                          frame_end;

  modport source (output valid, unit, channel, adc_code, frame_end, input ready);
  modport sink   (input valid, unit, channel, adc_code, frame_end, output ready);
endinterface

interface mfa_out_if;
  logic                            valid;
  logic                            ready;
  logic [mfa_pkg::SENS_NUM_W-1:0]  sensor_number;
  logic                            updated;
  logic [mfa_pkg::AVG_W-1:0]       average_count;
  logic [mfa_pkg::MV_W-1:0]        millivolts;
  logic                            last_result;

  modport source (output valid, sensor_number, updated, average_count, millivolts,
                  last_result, input ready);
  modport sink   (input valid, sensor_number, updated, average_count, millivolts,
                  last_result, output ready);
endinterface

// ===== rtl/mfa_accum.sv =====
// Sensor matching and per-frame sum and count accumulation.
// Depends on mfa_pkg.
module mfa_accum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  mfa_pkg::sample_t                  sample_i,
  input  logic [mfa_pkg::CHMAP_W-1:0]       channel_map_i,
  input  logic [mfa_pkg::UMAP_W-1:0]        unit_map_i,
  input  logic                              clear_i,
  input  logic [mfa_pkg::IDX_W-1:0]         rd_sel_i,
  output mfa_pkg::acc_rd_t                  rd_o
);

  logic [mfa_pkg::SUM_W-1:0]   sums_q   [mfa_pkg::NUM_SENSORS];
  logic [mfa_pkg::COUNT_W-1:0] counts_q [mfa_pkg::NUM_SENSORS];
  logic [mfa_pkg::COUNT_W-1:0] total_q;

  logic                        tag_ok;
  logic                        hit;
  logic [mfa_pkg::IDX_W-1:0]   hit_idx;
  logic                        take;

  assign tag_ok = (sample_i.channel <= mfa_pkg::MAX_CHANNEL) &&
                  (sample_i.unit <= mfa_pkg::MAX_UNIT);

  // Lowest matching sensor wins, so scan from the top down.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int s = mfa_pkg::NUM_SENSORS - 1; s >= 0; s--) begin
      if ((channel_map_i[4*s +: 4] == sample_i.channel) &&
          (unit_map_i[s] == sample_i.unit[0])) begin
        hit     = 1'b1;
        hit_idx = mfa_pkg::IDX_W'(s);
      end
    end
  end

  assign take = accept_i && (total_q < mfa_pkg::COUNT_W'(mfa_pkg::MAX_FRAME_SAMPLES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      for (int s = 0; s < mfa_pkg::NUM_SENSORS; s++) begin
        sums_q[s]   <= '0;
        counts_q[s] <= '0;
      end
    end else if (clear_i) begin
      total_q <= '0;
      for (int s = 0; s < mfa_pkg::NUM_SENSORS; s++) begin
        sums_q[s]   <= '0;
        counts_q[s] <= '0;
      end
    end else if (take) begin
      total_q <= total_q + mfa_pkg::COUNT_W'(1);
      if (tag_ok && hit) begin
        sums_q[hit_idx]   <= sums_q[hit_idx] + mfa_pkg::SUM_W'(sample_i.adc_code);
        counts_q[hit_idx] <= counts_q[hit_idx] + mfa_pkg::COUNT_W'(1);
      end
    end
  end

  assign rd_o.sum   = sums_q[rd_sel_i];
  assign rd_o.count = counts_q[rd_sel_i];

endmodule

// ===== rtl/mfa_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on mfa_pkg.
module mfa_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfa_pkg::div_req_t req_i,
  output mfa_pkg::div_rsp_t rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [mfa_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [mfa_pkg::DIV_VW-1:0]    rem_q;
  logic [mfa_pkg::DIV_VW-1:0]    div_q;
  logic [mfa_pkg::DIV_DW-1:0]    quo_q;

  logic [mfa_pkg::DIV_VW:0]      shifted;
  logic                          fits;
  logic [mfa_pkg::DIV_VW:0]      diff;

  assign shifted = {rem_q, quo_q[mfa_pkg::DIV_DW-1]};
  assign fits    = shifted >= {1'b0, div_q};
  assign diff    = shifted - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= mfa_pkg::DIV_CNT_W'(mfa_pkg::DIV_DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - mfa_pkg::DIV_CNT_W'(1);
        if (cnt_q == mfa_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      quo_q <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[mfa_pkg::DIV_DW-2:0], fits};
      rem_q <= fits ? diff[mfa_pkg::DIV_VW-1:0] : shifted[mfa_pkg::DIV_VW-1:0];
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/multichannel_frame_averager.sv =====
// Top level of the multichannel frame averager: configuration registers,
// frame-end sequencer, cached results and output register.
// Depends on mfa_pkg, mfa_channels, mfa_accum and mfa_div.
//
//   Channel     Dir  Handshake          Payload
//   samples_i   in   valid/ready        unit, channel, adc_code, frame_end
//   results_o   out  valid/ready        sensor_number, updated, average_count,
//                                       millivolts, last_result
//   cfg_*_i     in   write enable only  cfg_index_i, cfg_data_i
//
// A sample request without frame_end is taken while the block is idle, one per
// cycle. A request with frame_end starts the per-sensor sequence, during which
// no sample is taken. A sensor with samples makes one pass through the
// bit-serial divider for sum/count, then a multiply and a two-step fold that
// divides by 4095. A sensor without samples reports its cached values. A stalled
// sink holds the sequence at the output register. Reset is asynchronous and clears
// all state but the divider's operand, remainder and quotient registers.
module multichannel_frame_averager (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  mfa_in_if.sink                             samples_i,
  mfa_out_if.source                          results_o,
  input  logic                               cfg_we_i,
  input  logic [mfa_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mfa_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_MUL,
    ST_FOLD,
    ST_SCALE,
    ST_EMIT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [mfa_pkg::CHMAP_W-1:0] chmap_q;
  logic [mfa_pkg::UMAP_W-1:0]  umap_q;
  logic [mfa_pkg::FS_W-1:0]    fs_q;

  // Cached results, one entry per sensor.
  logic [mfa_pkg::AVG_W-1:0] cache_avg_q [mfa_pkg::NUM_SENSORS];
  logic [mfa_pkg::MV_W-1:0]  cache_mv_q  [mfa_pkg::NUM_SENSORS];

  logic [mfa_pkg::IDX_W-1:0]  sel_q;
  logic [mfa_pkg::AVG_W-1:0]  avg_q;
  logic [mfa_pkg::PROD_W-1:0] prod_q;
  logic [mfa_pkg::MV_W-1:0]   scale_hi_q;
  logic [mfa_pkg::MV_W:0]     fold_q;

  // Output register.
  logic                      out_valid_q;
  logic                      out_upd_q;
  logic [mfa_pkg::AVG_W-1:0] out_avg_q;
  logic [mfa_pkg::MV_W-1:0]  out_mv_q;
  logic                      out_last_q;

  logic              in_accept;
  logic              out_accept;
  logic              sel_last;
  logic              clear;
  mfa_pkg::sample_t  sample;
  mfa_pkg::acc_rd_t  acc_rd;
  mfa_pkg::div_req_t div_req;
  mfa_pkg::div_rsp_t div_rsp;
  logic [mfa_pkg::AVG_W-1:0] quo_avg;
  logic [mfa_pkg::RAW_W:0]   fold_rem;
  logic [mfa_pkg::MV_W-1:0]  mv_scaled;

  assign samples_i.ready = (state_q == ST_IDLE);
  assign in_accept       = samples_i.valid && samples_i.ready;
  assign out_accept      = out_valid_q && results_o.ready;
  assign sel_last        = (sel_q == mfa_pkg::IDX_W'(mfa_pkg::NUM_SENSORS - 1));
  assign clear           = out_accept && out_last_q;

  assign sample.unit     = samples_i.unit;
  assign sample.channel  = samples_i.channel;
  assign sample.adc_code = samples_i.adc_code;

  mfa_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .sample_i      (sample),
    .channel_map_i (chmap_q),
    .unit_map_i    (umap_q),
    .clear_i       (clear),
    .rd_sel_i      (sel_q),
    .rd_o          (acc_rd)
  );

  // The divider is started for the average only when the sensor has samples.
  always_comb begin
    div_req.start    = (state_q == ST_AVG_START) && (acc_rd.count != '0);
    div_req.dividend = mfa_pkg::DIV_DW'(acc_rd.sum);
    div_req.divisor  = mfa_pkg::DIV_VW'(acc_rd.count);
  end

  mfa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // The average of in-range samples never exceeds full scale; clamp anyway.
  assign quo_avg = (div_rsp.quotient > mfa_pkg::DIV_DW'(mfa_pkg::MAX_RAW)) ?
                   mfa_pkg::MAX_RAW : div_rsp.quotient[mfa_pkg::AVG_W-1:0];

  // Division of the product by 4095 without a divider. With the product split
  // as hi*4096 + lo it equals hi*4095 + (hi + lo); the fold register holds
  // hi + lo, which is split once more the same way. What is left is below
  // twice 4095, so one compare gives the last quotient bit.
  assign fold_rem  = (mfa_pkg::RAW_W+1)'(fold_q[mfa_pkg::MV_W:mfa_pkg::RAW_W]) +
                     {1'b0, fold_q[mfa_pkg::RAW_W-1:0]};
  assign mv_scaled = scale_hi_q + mfa_pkg::MV_W'(fold_q[mfa_pkg::MV_W:mfa_pkg::RAW_W]) +
                     mfa_pkg::MV_W'(fold_rem >= {1'b0, mfa_pkg::MAX_RAW});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chmap_q <= mfa_pkg::RESET_CHANNEL_MAP;
      umap_q  <= mfa_pkg::RESET_UNIT_MAP;
      fs_q    <= mfa_pkg::RESET_FULL_SCALE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mfa_pkg::CFG_CHANNEL_MAP: chmap_q <= cfg_data_i[mfa_pkg::CHMAP_W-1:0];
        mfa_pkg::CFG_UNIT_MAP:    umap_q  <= cfg_data_i[mfa_pkg::UMAP_W-1:0];
        mfa_pkg::CFG_FULL_SCALE:  fs_q    <= cfg_data_i[mfa_pkg::FS_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame-end sequencer with its registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= '0;
      avg_q       <= '0;
      prod_q      <= '0;
      scale_hi_q  <= '0;
      fold_q      <= '0;
      out_valid_q <= 1'b0;
      out_upd_q   <= 1'b0;
      out_avg_q   <= '0;
      out_mv_q    <= '0;
      out_last_q  <= 1'b0;
      for (int s = 0; s < mfa_pkg::NUM_SENSORS; s++) begin
        cache_avg_q[s] <= '0;
        cache_mv_q[s]  <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept && samples_i.frame_end) begin
            sel_q   <= '0;
            state_q <= ST_AVG_START;
          end
        end
        ST_AVG_START: begin
          if (acc_rd.count != '0) begin
            state_q <= ST_AVG_WAIT;
          end else begin
            // No samples this frame: report the cached values unchanged.
            out_valid_q <= 1'b1;
            out_upd_q   <= 1'b0;
            out_avg_q   <= cache_avg_q[sel_q];
            out_mv_q    <= cache_mv_q[sel_q];
            out_last_q  <= sel_last;
            state_q     <= ST_EMIT;
          end
        end
        ST_AVG_WAIT: begin
          if (div_rsp.done) begin
            avg_q   <= quo_avg;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= mfa_pkg::PROD_W'(avg_q) * mfa_pkg::PROD_W'(fs_q);
          state_q <= ST_FOLD;
        end
        ST_FOLD: begin
          scale_hi_q <= prod_q[mfa_pkg::PROD_W-1:mfa_pkg::RAW_W];
          fold_q     <= {1'b0, prod_q[mfa_pkg::PROD_W-1:mfa_pkg::RAW_W]} +
                        (mfa_pkg::MV_W+1)'(prod_q[mfa_pkg::RAW_W-1:0]);
          state_q    <= ST_SCALE;
        end
        ST_SCALE: begin
          cache_avg_q[sel_q] <= avg_q;
          cache_mv_q[sel_q]  <= mv_scaled;
          out_valid_q        <= 1'b1;
          out_upd_q          <= 1'b1;
          out_avg_q          <= avg_q;
          out_mv_q           <= mv_scaled;
          out_last_q         <= sel_last;
          state_q            <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_accept) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              sel_q   <= '0;
              state_q <= ST_IDLE;
            end else begin
              sel_q   <= sel_q + mfa_pkg::IDX_W'(1);
              state_q <= ST_AVG_START;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign results_o.valid         = out_valid_q;
  assign results_o.sensor_number = mfa_pkg::SENS_NUM_W'(sel_q);
  assign results_o.updated       = out_upd_q;
  assign results_o.average_count = out_avg_q;
  assign results_o.millivolts    = out_mv_q;
  assign results_o.last_result   = out_last_q;

`ifndef SYNTHESIS
  // Samples are never taken while a result is pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    samples_i.ready |-> !results_o.valid)
    else $error("sample taken while a result is pending");

  // The final result of a run always belongs to the highest sensor.
  a_last_sensor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (results_o.valid && results_o.last_result) |->
      (results_o.sensor_number == mfa_pkg::SENS_NUM_W'(mfa_pkg::NUM_SENSORS - 1)))
    else $error("last result on the wrong sensor");

  // Once the final result is taken, the block takes samples again.
  a_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (results_o.valid && results_o.ready && results_o.last_result) |=> samples_i.ready)
    else $error("block not ready after the last result");

  // The divider is only started while it is free.
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
`endif

endmodule
